// File: hdl/fit_policy_block_allocator_top_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FPBA_CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define FPBA_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fpba_pkg.sv
// Shared constants and types for the fit policy block allocator.
package fpba_pkg;

  localparam int FREE_ENTRIES_DEF = 64;
  localparam int USED_ENTRIES_DEF = 64;
  localparam int ADDR_BITS_DEF    = 32;

  localparam logic [31:0] ARENA_RESET = 32'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_ALT   = 2'd3
  } policy_t;

  localparam logic [1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [1:0] REG_ARENA_SIZE = 2'd1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_MOVE   = 6'b001000,
    S_FINAL  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

endpackage

// File: hdl/fpba_ram.sv
// Generic single write, single read RAM with registered read data.
module fpba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/fit_policy_block_allocator_top.sv
// Top level of the first, best or worst fit free list allocator.
// Allocator over an arena starting at address 0. The free list and the used
// table each live in a RAM as packed lists, front first, with a count register
// each. One request is handled at a time. An allocate scans the free list one
// entry per cycle, may close a gap left by a dropped entry, then shifts the used
// table up by one and inserts the new block. A free scans the used table until
// the newest match, closes the gap, shifts the free list up and inserts at the
// front. Errors answer after the scan and the decision state. The next request
// is taken back in the idle state after the response is accepted, once any
// pending initial free entry is written. The RAM read port, one entry per cycle,
// sets the pace of the scans and shifts. After reset or a write of arena_size
// the block writes the single initial free entry while idle.
module fit_policy_block_allocator_top
  import fpba_pkg::*;
#(
  parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = USED_ENTRIES_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_address,
  output logic [31:0] out_freed_size
);

  `include "fit_policy_block_allocator_top_defines.svh"

  localparam int FAW = $clog2(FREE_ENTRIES);
  localparam int UAW = $clog2(USED_ENTRIES);
  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam int MW  = (FCW > UCW) ? FCW : UCW;
  localparam int DW  = ADDR_BITS + 32;

  state_t               state_r, state_nxt;
  logic                 pend_r, pend_nxt;
  logic [FCW-1:0]       fcnt_r, fcnt_nxt;
  logic [UCW-1:0]       ucnt_r, ucnt_nxt;
  logic [1:0]           policy_r, policy_nxt;
  logic [31:0]          arena_r, arena_nxt;
  logic                 op_r, op_nxt;
  logic [31:0]          req_r, req_nxt;
  logic [31:0]          addr_r, addr_nxt;
  logic [MW-1:0]        iss_r, iss_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [MW-1:0]        chk_idx_r, chk_idx_nxt;
  logic                 stop_r, stop_nxt;
  logic                 found_r, found_nxt;
  logic [MW-1:0]        pick_idx_r, pick_idx_nxt;
  logic [ADDR_BITS-1:0] pick_base_r, pick_base_nxt;
  logic [31:0]          pick_len_r, pick_len_nxt;
  logic                 ph_r, ph_nxt;
  logic                 mv_sel_r, mv_sel_nxt;
  logic                 mv_up_r, mv_up_nxt;
  logic [MW-1:0]        mv_src_r, mv_src_nxt;
  logic [MW-1:0]        mv_left_r, mv_left_nxt;
  logic                 wv_r, wv_nxt;
  logic                 wv_sel_r, wv_sel_nxt;
  logic [MW-1:0]        wv_addr_r, wv_addr_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [31:0]          gaddr_r, gaddr_nxt;
  logic [31:0]          fsize_r, fsize_nxt;

  logic                 fram_we, fram_re, uram_we, uram_re;
  logic [FAW-1:0]       fram_waddr, fram_raddr;
  logic [UAW-1:0]       uram_waddr, uram_raddr;
  logic [DW-1:0]        fram_wdata, fram_rdata, uram_wdata, uram_rdata;

  logic [ADDR_BITS-1:0] req_a, addr_a;
  logic [31:0]          base_lo;
  logic [MW-1:0]        fcnt_x, ucnt_x, scan_cnt;
  logic                 scan_issue, mv_issue;
  logic [31:0]          f_len, u_len, new_len;
  logic [ADDR_BITS-1:0] f_base, u_base;
  logic                 better;

  // Fit request and address into the address width
  generate
    if (ADDR_BITS > 32) begin : g_wide
      assign req_a   = {{(ADDR_BITS-32){1'b0}}, req_r};
      assign addr_a  = {{(ADDR_BITS-32){1'b0}}, addr_r};
      assign base_lo = pick_base_r[31:0];
    end else if (ADDR_BITS == 32) begin : g_eq
      assign req_a   = req_r;
      assign addr_a  = addr_r;
      assign base_lo = pick_base_r;
    end else begin : g_narrow
      assign req_a   = req_r[ADDR_BITS-1:0];
      assign addr_a  = addr_r[ADDR_BITS-1:0];
      assign base_lo = {{(32-ADDR_BITS){1'b0}}, pick_base_r};
    end
  endgenerate

  fpba_ram #(.WIDTH(DW), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(fram_we), .waddr(fram_waddr), .wdata(fram_wdata),
    .re(fram_re), .raddr(fram_raddr), .rdata(fram_rdata)
  );

  fpba_ram #(.WIDTH(DW), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk(clk), .we(uram_we), .waddr(uram_waddr), .wdata(uram_wdata),
    .re(uram_re), .raddr(uram_raddr), .rdata(uram_rdata)
  );

  assign fcnt_x   = MW'(fcnt_r);
  assign ucnt_x   = MW'(ucnt_r);
  assign scan_cnt = (op_r == OP_FREE) ? ucnt_x : fcnt_x;
  assign f_len    = fram_rdata[31:0];
  assign f_base   = fram_rdata[DW-1:32];
  assign u_len    = uram_rdata[31:0];
  assign u_base   = uram_rdata[DW-1:32];
  assign new_len  = pick_len_r - req_r;

  assign scan_issue = (state_r == S_SCAN) && !stop_r && (iss_r < scan_cnt);
  assign mv_issue   = (state_r == S_MOVE) && (mv_left_r != '0);

  // Read ports serve the scan or the list shift
  assign fram_re    = (scan_issue && op_r == OP_ALLOC) || (mv_issue && !mv_sel_r);
  assign uram_re    = (scan_issue && op_r == OP_FREE) || (mv_issue && mv_sel_r);
  assign fram_raddr = (state_r == S_SCAN) ? iss_r[FAW-1:0] : mv_src_r[FAW-1:0];
  assign uram_raddr = (state_r == S_SCAN) ? iss_r[UAW-1:0] : mv_src_r[UAW-1:0];

  assign better = (policy_r == POL_WORST) ? (f_len > pick_len_r) : (f_len < pick_len_r);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && !pend_r;
  assign out_valid = (state_r == S_OUT);
  assign out_status          = st_r;
  assign out_granted_address = gaddr_r;
  assign out_freed_size      = fsize_r;

  // Next state and RAM writes
  always_comb begin
    state_nxt = state_r; pend_nxt = pend_r; fcnt_nxt = fcnt_r; ucnt_nxt = ucnt_r;
    policy_nxt = policy_r; arena_nxt = arena_r; op_nxt = op_r; req_nxt = req_r;
    addr_nxt = addr_r; iss_nxt = iss_r; chk_v_nxt = 1'b0; chk_idx_nxt = chk_idx_r;
    stop_nxt = stop_r; found_nxt = found_r; pick_idx_nxt = pick_idx_r;
    pick_base_nxt = pick_base_r; pick_len_nxt = pick_len_r; ph_nxt = ph_r;
    mv_sel_nxt = mv_sel_r; mv_up_nxt = mv_up_r; mv_src_nxt = mv_src_r;
    mv_left_nxt = mv_left_r; wv_nxt = 1'b0; wv_sel_nxt = wv_sel_r; wv_addr_nxt = wv_addr_r;
    st_nxt = st_r; gaddr_nxt = gaddr_r; fsize_nxt = fsize_r;
    fram_we = 1'b0; fram_waddr = '0; fram_wdata = '0;
    uram_we = 1'b0; uram_waddr = '0; uram_wdata = '0;

    case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          // write the single initial free block
          fram_we    = 1'b1;
          fram_wdata = {{ADDR_BITS{1'b0}}, arena_r};
          pend_nxt   = 1'b0;
        end else if (in_valid) begin
          op_nxt    = in_opcode;
          req_nxt   = in_request_size;
          addr_nxt  = in_block_address;
          iss_nxt   = '0;
          stop_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          iss_nxt = iss_r + 1'b1;
        end
        chk_v_nxt   = scan_issue;
        chk_idx_nxt = iss_r;
        if (chk_v_r && !stop_r) begin
          if (op_r == OP_ALLOC) begin
            if (f_len >= req_r && (!found_r || better)) begin
              found_nxt     = 1'b1;
              pick_idx_nxt  = chk_idx_r;
              pick_base_nxt = f_base;
              pick_len_nxt  = f_len;
              stop_nxt      = (policy_r == POL_FIRST);
            end
          end else if (u_base == addr_a) begin
            // newest match wins
            found_nxt     = 1'b1;
            pick_idx_nxt  = chk_idx_r;
            pick_base_nxt = u_base;
            pick_len_nxt  = u_len;
            stop_nxt      = 1'b1;
          end
        end
        if (!scan_issue && !chk_v_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        gaddr_nxt = '0;
        fsize_nxt = '0;
        ph_nxt    = 1'b0;
        mv_up_nxt = 1'b0;
        mv_src_nxt = pick_idx_r + 1'b1;
        if (!found_r) begin
          st_nxt    = (op_r == OP_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
          state_nxt = S_OUT;
        end else if (op_r == OP_ALLOC) begin
          if (ucnt_x == MW'(USED_ENTRIES)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_OUT;
          end else begin
            // shrink in place, or close the gap of a dropped entry
            if (new_len != '0) begin
              fram_we    = 1'b1;
              fram_waddr = pick_idx_r[FAW-1:0];
              fram_wdata = {pick_base_r + req_a, new_len};
              mv_left_nxt = '0;
            end else begin
              mv_left_nxt = fcnt_x - 1'b1 - pick_idx_r;
            end
            mv_sel_nxt = 1'b0;
            state_nxt  = S_MOVE;
          end
        end else begin
          if (fcnt_x == MW'(FREE_ENTRIES)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_OUT;
          end else begin
            mv_sel_nxt  = 1'b1;
            mv_left_nxt = ucnt_x - 1'b1 - pick_idx_r;
            state_nxt   = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        // read one entry, write it one place over in the next cycle
        if (mv_issue) begin
          mv_left_nxt = mv_left_r - 1'b1;
          mv_src_nxt  = mv_up_r ? mv_src_r - 1'b1 : mv_src_r + 1'b1;
          wv_nxt      = 1'b1;
          wv_sel_nxt  = mv_sel_r;
          wv_addr_nxt = mv_up_r ? mv_src_r + 1'b1 : mv_src_r - 1'b1;
        end
        if (wv_r) begin
          if (!wv_sel_r) begin
            fram_we    = 1'b1;
            fram_waddr = wv_addr_r[FAW-1:0];
            fram_wdata = fram_rdata;
          end else begin
            uram_we    = 1'b1;
            uram_waddr = wv_addr_r[UAW-1:0];
            uram_wdata = uram_rdata;
          end
        end
        if (!mv_issue && !wv_r) begin
          if (!ph_r) begin
            // open a slot at the front of the other list
            ph_nxt    = 1'b1;
            mv_up_nxt = 1'b1;
            if (op_r == OP_ALLOC) begin
              mv_sel_nxt  = 1'b1;
              mv_src_nxt  = ucnt_x - 1'b1;
              mv_left_nxt = ucnt_x;
            end else begin
              mv_sel_nxt  = 1'b0;
              mv_src_nxt  = fcnt_x - 1'b1;
              mv_left_nxt = fcnt_x;
            end
          end else begin
            state_nxt = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        st_nxt = ST_OK;
        if (op_r == OP_ALLOC) begin
          uram_we    = 1'b1;
          uram_wdata = {pick_base_r, req_r};
          ucnt_nxt   = ucnt_r + 1'b1;
          if (new_len == '0) begin
            fcnt_nxt = fcnt_r - 1'b1;
          end
          gaddr_nxt = base_lo;
        end else begin
          fram_we    = 1'b1;
          fram_wdata = {pick_base_r, pick_len_r};
          ucnt_nxt   = ucnt_r - 1'b1;
          fcnt_nxt   = fcnt_r + 1'b1;
          fsize_nxt  = pick_len_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes
    if (cfg_valid) begin
      if (cfg_index == REG_FIT_POLICY) begin
        policy_nxt = cfg_data[1:0];
      end else if (cfg_index == REG_ARENA_SIZE) begin
        arena_nxt = cfg_data;
        fcnt_nxt  = FCW'(1);
        ucnt_nxt  = '0;
        pend_nxt  = 1'b1;
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_r   <= 1'b1;
      fcnt_r   <= FCW'(1);
      ucnt_r   <= '0;
      policy_r <= POL_BEST;
      arena_r  <= ARENA_RESET;
      chk_v_r  <= 1'b0;
      wv_r     <= 1'b0;
      stop_r   <= 1'b0;
      found_r  <= 1'b0;
      ph_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      fcnt_r   <= fcnt_nxt;
      ucnt_r   <= ucnt_nxt;
      policy_r <= policy_nxt;
      arena_r  <= arena_nxt;
      chk_v_r  <= chk_v_nxt;
      wv_r     <= wv_nxt;
      stop_r   <= stop_nxt;
      found_r  <= found_nxt;
      ph_r     <= ph_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    iss_r       <= iss_nxt;
    chk_idx_r   <= chk_idx_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_base_r <= pick_base_nxt;
    pick_len_r  <= pick_len_nxt;
    mv_sel_r    <= mv_sel_nxt;
    mv_up_r     <= mv_up_nxt;
    mv_src_r    <= mv_src_nxt;
    mv_left_r   <= mv_left_nxt;
    wv_sel_r    <= wv_sel_nxt;
    wv_addr_r   <= wv_addr_nxt;
    st_r        <= st_nxt;
    gaddr_r     <= gaddr_nxt;
    fsize_r     <= fsize_nxt;
  end

  `FPBA_CHK_NOW(a_out_blocks_in, out_valid, !in_ready, "input taken while result pending")
  `FPBA_CHK_NOW(a_free_bound, 1'b1, fcnt_r <= FCW'(FREE_ENTRIES), "free count overflow")
  `FPBA_CHK_NOW(a_used_bound, 1'b1, ucnt_r <= UCW'(USED_ENTRIES), "used count overflow")
  `FPBA_CHK_NEXT(a_accept_scan, in_valid && in_ready, state_r == S_SCAN, "request not scanned")

endmodule

// File: tb/sv/fpba_checker.sv
// Checker for the allocator: predicts each response from the accepted requests.
`timescale 1ns / 100ps
module fpba_checker
  import fpba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_block_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_granted_address,
  input  logic [31:0] out_freed_size,
  output int          fail_count,
  output int          pending_count
);
  localparam int NF = FREE_ENTRIES_DEF;
  localparam int NU = USED_ENTRIES_DEF;

  typedef struct packed {
    status_t     status;
    logic [31:0] granted;
    logic [31:0] freed;
  } response_t;

  response_t   pending_responses[$];
  logic [1:0]  policy_q;
  logic [31:0] fl_base[$], fl_len[$], ul_base[$], ul_len[$];

  assign pending_count = pending_responses.size();

  // Rebuild the arena as one free block.
  task automatic reinit_arena(input logic [31:0] sz);
    fl_base = {32'd0};
    fl_len  = {sz};
    ul_base = {};
    ul_len  = {};
  endtask

  // Compute the response of one request and update the predicted tables.
  function automatic response_t predict_response(input logic op, input logic [31:0] req,
                                                 input logic [31:0] addr);
    response_t r;
    int pick;
    int hit;
    logic [31:0] b;
    r = '{ST_OK, 32'd0, 32'd0};
    if (op == OP_ALLOC) begin
      pick = -1;
      for (int i = 0; i < fl_len.size(); i++) begin
        if (fl_len[i] < req) continue;
        if (pick < 0) begin
          pick = i;
          if (policy_q == POL_FIRST) break;
        end else if (policy_q == POL_WORST) begin
          if (fl_len[i] > fl_len[pick]) pick = i;
        end else if (fl_len[i] < fl_len[pick]) begin
          pick = i;
        end
      end
      if (pick < 0) r.status = ST_NOFIT;
      else if (ul_base.size() >= NU) r.status = ST_FULL;
      else begin
        b = fl_base[pick];
        fl_base[pick] = b + req;
        fl_len[pick]  = fl_len[pick] - req;
        if (fl_len[pick] == 0) begin
          fl_base.delete(pick);
          fl_len.delete(pick);
        end
        ul_base.push_front(b);
        ul_len.push_front(req);
        r.granted = b;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < ul_base.size(); i++)
        if (ul_base[i] == addr) begin
          hit = i;
          break;
        end
      if (hit < 0) r.status = ST_NOTFOUND;
      else if (fl_base.size() >= NF) r.status = ST_FULL;
      else begin
        fl_base.push_front(ul_base[hit]);
        fl_len.push_front(ul_len[hit]);
        r.freed = ul_len[hit];
        ul_base.delete(hit);
        ul_len.delete(hit);
      end
    end
    return r;
  endfunction

  // Track configuration, predict on request, compare on response.
  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      fail_count <= 0;
      policy_q = POL_BEST;
      reinit_arena(ARENA_RESET);
      pending_responses = {};
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FIT_POLICY) policy_q = cfg_data[1:0];
        else if (cfg_index == REG_ARENA_SIZE) reinit_arena(cfg_data);
      end
      if (in_valid && in_ready)
        pending_responses.push_back(predict_response(in_opcode, in_request_size,
                                                     in_block_address));
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: unexpected response status=%0d", $time, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_responses.pop_front();
          if (out_status !== want.status || out_granted_address !== want.granted ||
              out_freed_size !== want.freed) begin
            $display("%0t: mismatch expected st=%0d ga=%h fs=%h actual st=%0d ga=%h fs=%h",
                     $time, want.status, want.granted, want.freed, out_status,
                     out_granted_address, out_freed_size);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/tb_fit_policy_block_allocator_top.sv
// Stimulus top for the allocator: configuration phases, directed and random requests.
`timescale 1ns / 100ps
module tb_fit_policy_block_allocator_top
  import fpba_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0, in_ready;
  logic        in_opcode = 1'b0;
  logic [31:0] in_request_size = '0, in_block_address = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_granted_address, out_freed_size;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_stall_pct, sent;
  logic [31:0] granted_log[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fit_policy_block_allocator_top dut (.*);
  fpba_checker chk (.*);

  // Stall the response side at the chosen rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (out_valid && out_ready) granted_log.push_back(out_granted_address);
  end

  // Drop valid and wait until every predicted response is back, plus a drain margin.
  task automatic drain_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Write one configuration register.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one request, honoring the sender idle rate; valid drops only while idle.
  task automatic send_request(input logic op, input logic [31:0] req, input logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_request_size  <= req;
    in_block_address <= addr;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Random request: mostly frees of granted bases and small allocations.
  task automatic random_request();
    logic [31:0] a;
    int k;
    k = $urandom_range(99);
    if (k < 45) send_request(OP_ALLOC, $urandom_range(1, 700), $urandom);
    else if (k < 80 && granted_log.size() > 0)
      send_request(OP_FREE, $urandom, granted_log[$urandom_range(granted_log.size() - 1)]);
    else if (k < 90) send_request(OP_ALLOC, $urandom, $urandom);
    else begin
      a = $urandom;
      send_request(OP_FREE, $urandom, a);
    end
    if (granted_log.size() > 200) granted_log.delete(0);
  endtask

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Directed: reset settings, extremes and special cases.
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd100, '0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(OP_FREE, '0, 32'd0);
    send_request(OP_FREE, '0, 32'd0);
    send_request(OP_FREE, '0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd65536, '0);
    drain_responses();
    write_reg(REG_ARENA_SIZE, 32'd0);
    send_request(OP_ALLOC, 32'd0, '0);
    send_request(OP_ALLOC, 32'd1, '0);
    drain_responses();
    write_reg(REG_ARENA_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_FIT_POLICY, 32'(POL_ALT));
    send_request(OP_ALLOC, 32'hFFFF_FFF0, '0);
    send_request(OP_ALLOC, 32'h10, '0);
    send_request(OP_FREE, '0, 32'hFFFF_FFF0);
    send_request(OP_ALLOC, 32'h20, '0);
    drain_responses();
    // Fill the used table to reach the table-full case.
    write_reg(REG_ARENA_SIZE, 32'd1000);
    write_reg(REG_FIT_POLICY, 32'(POL_FIRST));
    for (int i = 0; i < 66; i++) send_request(OP_ALLOC, 32'd1, '0);
    drain_responses();

    // Random phases over policies, arenas and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      granted_log = {};
      write_reg(REG_FIT_POLICY, ph % 3);
      write_reg(REG_ARENA_SIZE, (ph == 7) ? 32'd1 : $urandom_range(2000, 40000));
      for (int i = 0; i < 40; i++) begin
        random_request();
        if (i == 20) drain_responses();
      end
      drain_responses();
    end

    $display("Sent %0d requests across first, best and worst fit, arenas from 0 bytes", sent);
    $display("to 4 GB, with table-full, not-found and no-fit cases and mixed idling.");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// File: fit_policy_block_allocator_top.f
+incdir+hdl
hdl/fpba_pkg.sv
hdl/fpba_ram.sv
hdl/fit_policy_block_allocator_top.sv
tb/sv/fpba_checker.sv
tb/sv/tb_fit_policy_block_allocator_top.sv
